@@ rtl/core/hrsp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types and constants for the HTTP request stream parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

  localparam int MAX_REQUEST_BYTES = 8192;
  localparam int LIMIT_W           = 14;
  localparam int LEN_W             = 32;
  localparam int FIFO_DEPTH        = 4;
  localparam int PTR_W             = $clog2(FIFO_DEPTH);
  localparam int LVL_W             = $clog2(FIFO_DEPTH + 1);

  // Result kinds
  localparam logic [1:0] KIND_METHOD = 2'd0;
  localparam logic [1:0] KIND_PATH   = 2'd1;
  localparam logic [1:0] KIND_BODY   = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  // Finish status codes
  localparam logic [1:0] ST_OK_NOBODY = 2'd0;
  localparam logic [1:0] ST_OK_BODY   = 2'd1;
  localparam logic [1:0] ST_ERROR     = 2'd2;

  // One result item as it leaves the block
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [1:0]       status;
    logic [LEN_W-1:0] body_length;
    logic             last;
  } res_t;

  // Results of one request step: up to two, in order
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

  // Bytes of the "Content-Length: " header key
  function automatic logic [7:0] hdr_key_byte(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      4'd15:   c = 8'h20; // space
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/http_request_stream_parser_top.sv @@
// ----------------------------------------------------------------------------
// http_request_stream_parser_top
// HTTP/1.0 request line and Content-Length parser, one request byte a cycle while in_ready is high.
// ----------------------------------------------------------------------------
// Each request byte is parsed in the cycle it is accepted, so a new request
// byte can be taken every cycle while in_ready is high. A byte yields zero,
// one or two results (a method, path or body byte, then possibly the finish
// status); results go into a four-entry queue that delivers one per cycle
// while out_ready is high. in_ready drops while the queue holds more than
// two results, so bytes that add a second result, or a receiver that holds
// off, can stall the request stream.
// cfg_request_limit sets the most bytes taken per request (clamped to
// 1..8192) and must only be written while the block is idle.
module http_request_stream_parser_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hrsp_pkg::LIMIT_W-1:0]  cfg_request_limit,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_end_of_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_out_byte,
  output logic [1:0]                    out_status,
  output logic [hrsp_pkg::LEN_W-1:0]    out_body_length,
  output logic                          out_last
);

  localparam logic [hrsp_pkg::LVL_W-1:0] ROOM_LVL =
    hrsp_pkg::LVL_W'(hrsp_pkg::FIFO_DEPTH - 2);

  hrsp_pkg::push_t               push;
  hrsp_pkg::res_t                head;
  logic                          step;
  logic                          pop;
  logic [hrsp_pkg::LVL_W-1:0]    level;

  assign cfg_ready = 1'b1;
  assign in_ready  = (level <= ROOM_LVL);
  assign step      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;

  hrsp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_limit   (cfg_request_limit),
    .step        (step),
    .data_byte   (in_data_byte),
    .end_of_data (in_end_of_data),
    .push        (push)
  );

  hrsp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .level     (level)
  );

  assign out_kind        = head.kind;
  assign out_out_byte    = head.data;
  assign out_status      = head.status;
  assign out_body_length = head.body_length;
  assign out_last        = head.last;

  // Queue never holds more than its depth
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= hrsp_pkg::LVL_W'(hrsp_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // Results only appear for an accepted request byte
  a_push_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    push.num != 2'd0 |-> step)
    else $error("result pushed without a request");

  // Every finish result closes the request
  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == hrsp_pkg::KIND_FINISH |-> out_last)
    else $error("finish result without last");

  // Reset leaves the queue empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> level == '0)
    else $error("result queue not empty after reset");

endmodule

@@ rtl/core/hrsp_parse.sv @@
// ----------------------------------------------------------------------------
// hrsp_parse
// Per-byte parser step: phase machine, header matchers, length accumulator
// and request limit register. Emits up to two results per request byte.
// ----------------------------------------------------------------------------
module hrsp_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hrsp_pkg::LIMIT_W-1:0]  cfg_limit,
  input  logic                          step,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_data,
  output hrsp_pkg::push_t               push
);

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_PATH,
    PH_REST,
    PH_HEAD,
    PH_BODY,
    PH_DRAIN
  } phase_t;

  localparam logic [1:0] KIND_METHOD = hrsp_pkg::KIND_METHOD;
  localparam logic [1:0] KIND_PATH   = hrsp_pkg::KIND_PATH;
  localparam logic [1:0] KIND_BODY   = hrsp_pkg::KIND_BODY;
  localparam logic [1:0] KIND_FINISH = hrsp_pkg::KIND_FINISH;

  localparam logic [1:0] ST_OK_NOBODY = hrsp_pkg::ST_OK_NOBODY;
  localparam logic [1:0] ST_OK_BODY   = hrsp_pkg::ST_OK_BODY;
  localparam logic [1:0] ST_ERROR     = hrsp_pkg::ST_ERROR;

  localparam int CW = hrsp_pkg::LIMIT_W;
  localparam int LW = hrsp_pkg::LEN_W;
  localparam logic [CW-1:0] CNT_MAX   = {CW{1'b1}};
  localparam logic [CW-1:0] LIMIT_TOP = CW'(hrsp_pkg::MAX_REQUEST_BYTES);
  localparam logic [LW-1:0] LEN_MAX   = {LW{1'b1}};

  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_Z  = 8'h5A;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;

  phase_t          phase_r, phase_nxt;
  logic [CW-1:0]   limit_r;
  logic [CW-1:0]   method_cnt_r, method_cnt_nxt;
  logic [CW-1:0]   path_cnt_r, path_cnt_nxt;
  logic [CW-1:0]   taken_r, taken_nxt;
  logic [4:0]      hdr_idx_r, hdr_idx_nxt;
  logic [2:0]      blank_idx_r, blank_idx_nxt;
  logic            len_seen_r, len_seen_nxt;
  logic            digits_r, digits_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [LW-1:0]   remain_r, remain_nxt;

  logic [CW-1:0]   lim;
  logic            data_vld;
  logic [1:0]      data_kind;
  logic            done;
  logic            term;
  logic [1:0]      st;
  logic [LW-1:0]   fin_len;
  logic [LW+3:0]   len_x10;
  logic [7:0]      blank_key;
  hrsp_pkg::res_t  data_item;
  hrsp_pkg::res_t  fin_item;

  function automatic logic [1:0] end_status(input phase_t ph, input logic seen);
    logic [1:0] s;
    case (ph)
      PH_HEAD: s = seen ? ST_ERROR : ST_OK_NOBODY;
      PH_BODY: s = ST_OK_BODY;
      default: s = ST_ERROR;
    endcase
    return s;
  endfunction

  always_comb begin
    lim = limit_r;
    if (lim == '0) begin
      lim = CW'(1);
    end
    if (lim > LIMIT_TOP) begin
      lim = LIMIT_TOP;
    end
  end

  assign len_x10 = ({4'b0, len_r} << 3) + ({4'b0, len_r} << 1)
                 + {{(LW){1'b0}}, data_byte[3:0]};

  always_comb begin
    case (blank_idx_r[1:0])
      2'd0, 2'd2: blank_key = CH_CR;
      default:    blank_key = CH_LF;
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    method_cnt_nxt = method_cnt_r;
    path_cnt_nxt   = path_cnt_r;
    taken_nxt      = taken_r;
    hdr_idx_nxt    = hdr_idx_r;
    blank_idx_nxt  = blank_idx_r;
    len_seen_nxt   = len_seen_r;
    digits_nxt     = digits_r;
    len_nxt        = len_r;
    remain_nxt     = remain_r;
    data_vld       = 1'b0;
    data_kind      = KIND_METHOD;
    done           = 1'b0;
    term           = 1'b0;
    st             = ST_OK_NOBODY;
    fin_len        = '0;

    if (step) begin
      if (phase_r == PH_DRAIN || phase_r > PH_DRAIN) begin
        // Ignore bytes until the request's last byte, then re-arm
        if (end_of_data) begin
          phase_nxt      = PH_METHOD;
          method_cnt_nxt = '0;
          path_cnt_nxt   = '0;
          taken_nxt      = '0;
          hdr_idx_nxt    = '0;
          blank_idx_nxt  = '0;
          len_seen_nxt   = 1'b0;
          digits_nxt     = 1'b0;
          len_nxt        = '0;
          remain_nxt     = '0;
        end else begin
          phase_nxt = PH_DRAIN;
        end
      end else begin
        if (data_byte == 8'h00) begin
          term = 1'b1;
        end else begin
          case (phase_r)
            PH_METHOD: begin
              if (data_byte >= CH_A && data_byte <= CH_Z) begin
                data_vld  = 1'b1;
                data_kind = KIND_METHOD;
                if (method_cnt_r < CNT_MAX) begin
                  method_cnt_nxt = method_cnt_r + CW'(1);
                end
              end else if (data_byte == CH_SP && method_cnt_r != '0) begin
                phase_nxt = PH_PATH;
              end else begin
                done = 1'b1;
                st   = ST_ERROR;
              end
            end
            PH_PATH: begin
              if (data_byte == CH_SP || data_byte == CH_LF) begin
                if (path_cnt_r == '0) begin
                  done = 1'b1;
                  st   = ST_ERROR;
                end else begin
                  phase_nxt = (data_byte == CH_SP) ? PH_REST : PH_HEAD;
                end
              end else begin
                data_vld  = 1'b1;
                data_kind = KIND_PATH;
                if (path_cnt_r < CNT_MAX) begin
                  path_cnt_nxt = path_cnt_r + CW'(1);
                end
              end
            end
            PH_REST: begin
              if (data_byte == CH_LF) begin
                phase_nxt = PH_HEAD;
              end
            end
            PH_HEAD: begin
              if (digits_r) begin
                if (data_byte >= CH_0 && data_byte <= CH_9) begin
                  // Saturate once the value leaves 32 bits
                  len_nxt = (len_x10[LW+3:LW] != 4'd0) ? LEN_MAX : len_x10[LW-1:0];
                end else begin
                  digits_nxt = 1'b0;
                end
              end
              if (!len_seen_r) begin
                if (data_byte == hrsp_pkg::hdr_key_byte(hdr_idx_r[3:0])) begin
                  hdr_idx_nxt = {1'b0, hdr_idx_r[3:0]} + 5'd1;
                end else begin
                  hdr_idx_nxt = (data_byte == CH_C) ? 5'd1 : 5'd0;
                end
                if (hdr_idx_nxt[4]) begin
                  len_seen_nxt = 1'b1;
                  digits_nxt   = 1'b1;
                  len_nxt      = '0;
                end
              end
              if (data_byte == blank_key) begin
                blank_idx_nxt = {1'b0, blank_idx_r[1:0]} + 3'd1;
              end else begin
                blank_idx_nxt = (data_byte == CH_CR) ? 3'd1 : 3'd0;
              end
              if (blank_idx_nxt[2]) begin
                if (!len_seen_nxt) begin
                  done = 1'b1;
                  st   = ST_OK_NOBODY;
                end else if (len_nxt == '0) begin
                  done = 1'b1;
                  st   = ST_OK_BODY;
                end else begin
                  phase_nxt  = PH_BODY;
                  remain_nxt = len_nxt;
                end
              end
            end
            default: begin
              // Body byte: pass it on and count down the length
              data_vld  = 1'b1;
              data_kind = KIND_BODY;
              if (remain_r != '0) begin
                remain_nxt = remain_r - LW'(1);
              end
              if (remain_nxt == '0) begin
                done = 1'b1;
                st   = ST_OK_BODY;
              end
            end
          endcase
        end

        if (taken_r < lim) begin
          taken_nxt = taken_r + CW'(1);
        end
        if (!done && (term || end_of_data || taken_nxt >= lim)) begin
          done = 1'b1;
          st   = end_status(phase_nxt, len_seen_nxt);
        end

        fin_len = len_nxt;
        if (done) begin
          if (end_of_data) begin
            phase_nxt      = PH_METHOD;
            method_cnt_nxt = '0;
            path_cnt_nxt   = '0;
            taken_nxt      = '0;
            hdr_idx_nxt    = '0;
            blank_idx_nxt  = '0;
            len_seen_nxt   = 1'b0;
            digits_nxt     = 1'b0;
            len_nxt        = '0;
            remain_nxt     = '0;
          end else begin
            phase_nxt = PH_DRAIN;
          end
        end
      end
    end
  end

  always_comb begin
    data_item.kind        = data_kind;
    data_item.data        = data_byte;
    data_item.status      = ST_OK_NOBODY;
    data_item.body_length = '0;
    data_item.last        = 1'b0;

    fin_item.kind        = KIND_FINISH;
    fin_item.data        = 8'h00;
    fin_item.status      = st;
    fin_item.body_length = fin_len;
    fin_item.last        = 1'b1;

    push.num    = {1'b0, data_vld} + {1'b0, done};
    push.first  = data_vld ? data_item : fin_item;
    push.second = fin_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_METHOD;
      limit_r      <= CW'(hrsp_pkg::MAX_REQUEST_BYTES);
      method_cnt_r <= '0;
      path_cnt_r   <= '0;
      taken_r      <= '0;
      hdr_idx_r    <= '0;
      blank_idx_r  <= '0;
      len_seen_r   <= 1'b0;
      digits_r     <= 1'b0;
      len_r        <= '0;
      remain_r     <= '0;
    end else begin
      phase_r      <= phase_nxt;
      method_cnt_r <= method_cnt_nxt;
      path_cnt_r   <= path_cnt_nxt;
      taken_r      <= taken_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      blank_idx_r  <= blank_idx_nxt;
      len_seen_r   <= len_seen_nxt;
      digits_r     <= digits_nxt;
      len_r        <= len_nxt;
      remain_r     <= remain_nxt;
      if (cfg_we) begin
        limit_r <= cfg_limit;
      end
    end
  end

endmodule

@@ rtl/core/hrsp_out_fifo.sv @@
// ----------------------------------------------------------------------------
// hrsp_out_fifo
// Result queue: takes up to two results per cycle, hands out one per cycle on pop.
// ----------------------------------------------------------------------------
module hrsp_out_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hrsp_pkg::push_t              push,
  input  logic                         pop,
  output hrsp_pkg::res_t               head,
  output logic                         not_empty,
  output logic [hrsp_pkg::LVL_W-1:0]   level
);

  localparam int PW = hrsp_pkg::PTR_W;
  localparam int VW = hrsp_pkg::LVL_W;

  hrsp_pkg::res_t mem [hrsp_pkg::FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [VW-1:0]  level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.num);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    level_nxt  = level_r + VW'(push.num) - VW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr_r + PW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  assign head      = mem[rd_ptr_r];
  assign not_empty = (level_r != '0);
  assign level     = level_r;

endmodule

@@ bench/tb_http_request_stream_parser_top.sv @@
// ----------------------------------------------------------------------------
// tb_http_request_stream_parser_top
// Self-checking bench for the HTTP request stream parser. Request bytes are
// fed as directed cases and then as random, mostly well-formed requests
// (method, path, headers with or without a length field, body) mixed with
// noise, truncation and stray zero bytes. A scoreboard runs its own parser
// model on every accepted request and checks each result in order. The
// request limit is changed between phases while the block is idle. Both
// channels idle at random and the receiver holds off once to fill the block.
// ----------------------------------------------------------------------------
module tb_http_request_stream_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_METHOD = hrsp_pkg::KIND_METHOD;
  localparam logic [1:0] KIND_PATH   = hrsp_pkg::KIND_PATH;
  localparam logic [1:0] KIND_BODY   = hrsp_pkg::KIND_BODY;
  localparam logic [1:0] KIND_FINISH = hrsp_pkg::KIND_FINISH;

  localparam logic [1:0] ST_OK_EMPTY = hrsp_pkg::ST_OK_NOBODY;
  localparam logic [1:0] ST_OK_BODY  = hrsp_pkg::ST_OK_BODY;
  localparam logic [1:0] ST_ERROR    = hrsp_pkg::ST_ERROR;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [8*16-1:0] LENGTH_KEY = "Content-Length: ";
  localparam logic [31:0]     LENGTH_TOP = 32'hFFFF_FFFF;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 400;

  typedef enum logic [2:0] {
    P_METHOD, P_PATH, P_SKIP_LINE, P_HEADERS, P_BODY, P_DRAIN
  } parse_phase_t;

  class request_parse_scoreboard;
    hrsp_pkg::res_t expected_results[$];
    int             errors;

    logic [13:0]  limit_reg;
    parse_phase_t phase;
    logic [13:0]  method_cnt;
    logic [13:0]  path_cnt;
    logic [13:0]  taken;
    logic [4:0]   key_pos;
    logic [2:0]   crlf_pos;
    bit           len_seen;
    bit           in_digits;
    logic [31:0]  len_val;
    logic [31:0]  body_left;

    function new();
      errors    = 0;
      limit_reg = 14'd8192;
      rearm();
    endfunction

    function void rearm();
      phase      = P_METHOD;
      method_cnt = '0;
      path_cnt   = '0;
      taken      = '0;
      key_pos    = '0;
      crlf_pos   = '0;
      len_seen   = 1'b0;
      in_digits  = 1'b0;
      len_val    = '0;
      body_left  = '0;
    endfunction

    function void set_limit(logic [13:0] v);
      limit_reg = v;
    endfunction

    function void expect_item(logic [1:0] kind, logic [7:0] data, logic [1:0] status,
                              logic [31:0] blen, logic last);
      hrsp_pkg::res_t item;
      item.kind        = kind;
      item.data        = data;
      item.status      = status;
      item.body_length = blen;
      item.last        = last;
      expected_results.push_back(item);
    endfunction

    function logic [1:0] close_status();
      case (phase)
        P_HEADERS: return len_seen ? ST_ERROR : ST_OK_EMPTY;
        P_BODY:    return ST_OK_BODY;
        default:   return ST_ERROR;
      endcase
    endfunction

    // Length digits, length key match and blank line match for one header byte
    function void scan_header(logic [7:0] b);
      logic [63:0] acc;
      logic [3:0]  i;
      logic [1:0]  j;
      if (in_digits) begin
        if (b >= "0" && b <= "9") begin
          acc = {32'd0, len_val} * 64'd10 + {56'd0, b - 8'h30};
          len_val = (acc > {32'd0, LENGTH_TOP}) ? LENGTH_TOP : acc[31:0];
        end else begin
          in_digits = 1'b0;
        end
      end
      if (!len_seen) begin
        i = key_pos[3:0];
        if (b == LENGTH_KEY[8*(15-i) +: 8]) begin
          key_pos = {1'b0, i} + 5'd1;
        end else begin
          key_pos = (b == "C") ? 5'd1 : 5'd0;
        end
        if (key_pos >= 5'd16) begin
          key_pos   = 5'd16;
          len_seen  = 1'b1;
          in_digits = 1'b1;
          len_val   = '0;
        end
      end
      j = crlf_pos[1:0];
      if (b == (j[0] ? CH_LF : CH_CR)) begin
        crlf_pos = {1'b0, j} + 3'd1;
      end else begin
        crlf_pos = (b == CH_CR) ? 3'd1 : 3'd0;
      end
    endfunction

    function void note_request(logic [7:0] b, logic eod);
      logic [13:0] lim;
      bit          done;
      logic [1:0]  st;
      done = 1'b0;
      st   = ST_OK_EMPTY;
      if (limit_reg == 14'd0) begin
        lim = 14'd1;
      end else if (limit_reg > 14'(hrsp_pkg::MAX_REQUEST_BYTES)) begin
        lim = 14'(hrsp_pkg::MAX_REQUEST_BYTES);
      end else begin
        lim = limit_reg;
      end

      if (phase == P_DRAIN) begin
        if (eod) rearm();
        return;
      end

      if (b == 8'h00) begin
        done = 1'b1;
        st   = close_status();
      end else begin
        case (phase)
          P_METHOD: begin
            if (b >= "A" && b <= "Z") begin
              expect_item(KIND_METHOD, b, ST_OK_EMPTY, '0, 1'b0);
              if (method_cnt != '1) method_cnt++;
            end else if (b == CH_SPACE && method_cnt != '0) begin
              phase = P_PATH;
            end else begin
              done = 1'b1;
              st   = ST_ERROR;
            end
          end
          P_PATH: begin
            if (b == CH_SPACE || b == CH_LF) begin
              if (path_cnt == '0) begin
                done = 1'b1;
                st   = ST_ERROR;
              end else begin
                phase = (b == CH_SPACE) ? P_SKIP_LINE : P_HEADERS;
              end
            end else begin
              expect_item(KIND_PATH, b, ST_OK_EMPTY, '0, 1'b0);
              if (path_cnt != '1) path_cnt++;
            end
          end
          P_SKIP_LINE: begin
            if (b == CH_LF) phase = P_HEADERS;
          end
          P_HEADERS: begin
            scan_header(b);
            if (crlf_pos >= 3'd4) begin
              if (!len_seen) begin
                done = 1'b1;
                st   = ST_OK_EMPTY;
              end else if (len_val == '0) begin
                done = 1'b1;
                st   = ST_OK_BODY;
              end else begin
                phase     = P_BODY;
                body_left = len_val;
              end
            end
          end
          default: begin
            expect_item(KIND_BODY, b, ST_OK_EMPTY, '0, 1'b0);
            if (body_left != '0) body_left--;
            if (body_left == '0) begin
              done = 1'b1;
              st   = ST_OK_BODY;
            end
          end
        endcase
      end

      if (taken < lim) taken++;
      if (!done && (eod || taken >= lim)) begin
        done = 1'b1;
        st   = close_status();
      end

      if (done) begin
        expect_item(KIND_FINISH, 8'h00, st, len_val, 1'b1);
        if (eod) begin
          rearm();
        end else begin
          phase = P_DRAIN;
        end
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(hrsp_pkg::res_t got);
      hrsp_pkg::res_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h", got.kind, got.data));
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.data !== want.data)
        report($sformatf("byte %02h, want %02h", got.data, want.data));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.body_length !== want.body_length)
        report($sformatf("body_length %0d, want %0d", got.body_length, want.body_length));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [hrsp_pkg::LIMIT_W-1:0]  cfg_request_limit;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    in_data_byte;
  logic                          in_end_of_data;
  logic                          out_valid;
  logic                          out_ready;
  logic [1:0]                    out_kind;
  logic [7:0]                    out_out_byte;
  logic [1:0]                    out_status;
  logic [hrsp_pkg::LEN_W-1:0]    out_body_length;
  logic                          out_last;

  request_parse_scoreboard sb;
  logic [7:0] req_bytes[$];
  int         send_idle_pct = 29;
  int         recv_idle_pct = 46;
  int         hold_off      = 0;

  http_request_stream_parser_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_request_limit(cfg_request_limit),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_data   (in_end_of_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_out_byte     (out_out_byte),
    .out_status       (out_status),
    .out_body_length  (out_body_length),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(8'(s[i]));
  endfunction

  // Build one random request; most are well formed with random content
  function automatic void compose_request();
    int         pick;
    int         n;
    int         val;
    int         body_n;
    int         len_pos;
    bit         has_len;
    logic [7:0] c;
    req_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 10) begin
      n = $urandom_range(1, 12);
      repeat (n) req_bytes.push_back(8'($urandom_range(255)));
      return;
    end

    n = $urandom_range(1, 6);
    repeat (n) req_bytes.push_back(8'(8'h41 + $urandom_range(25)));
    req_bytes.push_back(CH_SPACE);
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      do c = 8'($urandom_range(1, 255)); while (c == CH_SPACE || c == CH_LF);
      req_bytes.push_back(c);
    end
    if ($urandom_range(1) == 1) begin
      add_text(" HTTP/1.0\r\n");
    end else begin
      req_bytes.push_back(CH_LF);
    end

    has_len = ($urandom_range(3) != 0);
    n       = $urandom_range(0, 3);
    len_pos = $urandom_range(0, n);
    body_n  = $urandom_range(0, 3);
    if (n == 0 && !has_len) add_text("\r\n");
    for (int k = 0; k <= n; k++) begin
      if (has_len && k == len_pos) begin
        add_text("Content-Length: ");
        case ($urandom_range(7))
          0, 1, 2, 3: begin
            val = $urandom_range(0, 24);
            add_text($sformatf("%0d", val));
            body_n = val;
          end
          4: add_text("4294967295");
          5: add_text("4294967296");
          6: add_text("184467440737095516159");
          default: begin
            add_text("0007");
            body_n = 7;
          end
        endcase
        if ($urandom_range(7) == 0) add_text("x9");
        add_text("\r\n");
        // a second length field must be ignored
        if ($urandom_range(5) == 0) add_text("Content-Length: 5\r\n");
      end
      if (k < n) begin
        case ($urandom_range(4))
          0: add_text("Host: ");
          1: add_text("Content-Type: ");
          2: add_text("Content-Lengt: ");
          3: add_text("CContent-Length: ");
          default: begin
            repeat ($urandom_range(1, 6)) req_bytes.push_back(8'(8'h61 + $urandom_range(25)));
            add_text(": ");
          end
        endcase
        repeat ($urandom_range(0, 8)) req_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
        add_text("\r\n");
      end
    end
    add_text("\r\n");

    case ($urandom_range(9))
      6, 7:    body_n = $urandom_range(0, body_n);
      8, 9:    body_n = body_n + $urandom_range(1, 4);
      default: ;
    endcase
    // a length field inside the body is plain data
    if ($urandom_range(11) == 0) add_text("Content-Length: 3");
    repeat (body_n) req_bytes.push_back(8'($urandom_range(1, 255)));

    if ($urandom_range(11) == 0) begin
      n = $urandom_range(1, req_bytes.size());
      while (req_bytes.size() > n) req_bytes.delete(req_bytes.size() - 1);
    end
    if ($urandom_range(19) == 0) req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'h00;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eod);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_data <= eod;
    do @(posedge clk); while (!in_ready);
    sb.note_request(b, eod);
  endtask

  // Send the built request, end_of_data on its last byte
  task automatic send_request();
    for (int i = 0; i < req_bytes.size(); i++) begin
      send_byte(req_bytes[i], (i == req_bytes.size() - 1));
    end
    req_bytes.delete();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [13:0] v);
    cfg_valid         <= 1'b1;
    cfg_request_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_limit(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [13:0] lim, input int snd_pct, input int rcv_pct,
                           input int n_items, input int hold);
    int sent;
    wait_idle();
    write_limit(lim);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    hold_off      = hold;
    sent          = 0;
    while (sent < n_items) begin
      compose_request();
      sent += req_bytes.size();
      send_request();
    end
  endtask

  // Receiver: check every result, stall at random or hold off on request
  initial begin
    hrsp_pkg::res_t seen;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        seen.kind        = out_kind;
        seen.data        = out_out_byte;
        seen.status      = out_status;
        seen.body_length = out_body_length;
        seen.last        = out_last;
        sb.check_result(seen);
      end
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("http_request_stream_parser_top test failed");
    $finish;
  end

  initial begin
    sb = new();
    rst_n             <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_request_limit <= '0;
    in_valid          <= 1'b0;
    in_data_byte      <= '0;
    in_end_of_data    <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty method then drain, bad method byte, empty path,
    // blank line without length, zero byte terminator, end of data in path
    req_bytes.push_back(CH_SPACE);
    req_bytes.push_back(8'hFF);
    send_request();
    add_text("G");
    req_bytes.push_back(8'h01);
    send_request();
    add_text("P  ");
    send_request();
    add_text("Z /\n\r\n\r\n");
    send_request();
    add_text("A");
    req_bytes.push_back(8'h00);
    req_bytes.push_back(8'h80);
    send_request();
    add_text("A /x");
    send_request();

    run_phase(14'd8192, 29, 46, 250, 0);
    run_phase(14'd1, 29, 46, 60, 0);
    run_phase(14'h3FFF, 46, 29, 380, 0);

    // One request whose long body is cut short by its last byte
    add_text("GET /big\nContent-Length: 100000\r\n\r\n");
    while (req_bytes.size() < 120) req_bytes.push_back(8'($urandom_range(1, 255)));
    send_request();

    run_phase(14'd0, 46, 29, 60, 0);
    run_phase(14'd37, 0, 0, 300, HOLD_CYCLES);
    run_phase(14'($urandom_range(2, 300)), 0, 0, 230, 0);

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("http_request_stream_parser_top test passed");
    end else begin
      $display("http_request_stream_parser_top test failed");
    end
    $finish;
  end

endmodule
